FILE: rtl/core/cop_pkg.sv
`default_nettype none

package cop_pkg;

    localparam int MAX_FRAME_DEF = 4096;
    localparam int MAX_SCALE_DEF = 8;

    localparam int BEAT_ONE    = 256;
    localparam int BEAT_THRESH = 102;
    localparam int HALF_SECOND = 500;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEXT_RGB,
        CFG_BASE_SCALE,
        CFG_BLINK_COLON,
        CFG_FRAME_WIDTH,
        CFG_FRAME_HEIGHT
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_SHADOW,
        KIND_TEXT
    } kind_t;

    typedef logic [3:0] glyph_t;

    localparam glyph_t GLYPH_ONE   = 4'd1;
    localparam glyph_t GLYPH_COLON = 4'd10;
    localparam glyph_t GLYPH_BLANK = 4'd15;

    typedef struct packed {
        logic main;
        logic shadow;
    } hit_t;

    localparam logic [4:0] FONT_ROM [0:10][0:6] = '{
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F},
        '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E},
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
        '{5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
        '{5'h00, 5'h00, 5'h04, 5'h00, 5'h04, 5'h00, 5'h00}
    };

    function automatic logic [4:0] font_row(glyph_t g, logic [2:0] r);
        logic [4:0] bits;
        bits = 5'd0;
        if (g <= GLYPH_COLON && r <= 3'd6)
        begin
            bits = FONT_ROM[g][r];
        end
        return bits;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cop_glyph_hit.sv
`default_nettype none

module cop_glyph_hit
    import cop_pkg::*;
#(
    parameter int SW = 4,
    parameter int LW = 6
)
(
    input  wire glyph_t       glyph,
    input  wire [LW-1:0]      lx,
    input  wire [LW-1:0]      ly,
    input  wire               ly_ok,
    input  wire [SW-1:0]      s,
    output hit_t              hit
);

    logic [LW-1:0] mult [1:7];
    logic [LW-1:0] lxs;
    logic [LW-1:0] lys;
    logic [2:0]    mcol;
    logic [2:0]    mrow;
    logic [2:0]    scol;
    logic [2:0]    srow;
    logic [4:0]    mbits;
    logic [4:0]    sbits;
    logic          m_in;
    logic          s_in;

    always_comb
    begin
        for (int k = 1; k <= 7; k++)
        begin
            mult[k] = LW'(k * int'(s));
        end
        lxs  = lx - LW'(1);
        lys  = ly - LW'(1);
        mcol = 3'd0;
        scol = 3'd0;
        for (int k = 1; k <= 4; k++)
        begin
            mcol = mcol + 3'(lx >= mult[k]);
            scol = scol + 3'(lxs >= mult[k]);
        end
        mrow = 3'd0;
        srow = 3'd0;
        for (int k = 1; k <= 6; k++)
        begin
            mrow = mrow + 3'(ly >= mult[k]);
            srow = srow + 3'(lys >= mult[k]);
        end
        m_in  = ly_ok && (lx < mult[5]) && (ly < mult[7]);
        s_in  = ly_ok && (lx != '0) && (lx <= mult[5]) && (ly != '0) && (ly <= mult[7]);
        mbits = font_row(glyph, mrow);
        sbits = font_row(glyph, srow);
        hit.main   = m_in && mbits[3'd4 - mcol];
        hit.shadow = s_in && sbits[3'd4 - scol];
    end

endmodule

`default_nettype wire

FILE: rtl/core/clock_overlay_pixel_generator.sv
// Pipeline: a pixel accepted with start passes the four-stage register
// pipeline (s1, s2, s3, kind/rgb) and gives its result with done high.
// Throughput: one pixel per clock; busy is always low and nothing stalls.
// Reset: rst_n clears the pipeline valid bits at once and loads the register
// reset values; the receiver cannot stall, so each result shows for one cycle.
`default_nettype none

module clock_overlay_pixel_generator
    import cop_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF,
    parameter int MAX_SCALE = MAX_SCALE_DEF
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire [11:0]           pixel_x,
    input  wire [11:0]           pixel_y,
    input  wire [4:0]            hours,
    input  wire [5:0]            minutes,
    input  wire [9:0]            millis,
    input  wire [8:0]            beat_level,
    input  wire                  wr_en,
    input  wire [CFG_IDX_W-1:0]  wr_index,
    input  wire [CFG_DATA_W-1:0] wr_data,
    output logic                 done,
    output logic [1:0]           pixel_kind,
    output logic [23:0]          pixel_rgb
);

    localparam int SW = $clog2(MAX_SCALE + 2);
    localparam int FW = $clog2(MAX_FRAME + 1);
    localparam int XW = ((FW > 12) ? FW : 12) + 2;
    localparam int LW = $clog2(7 * (MAX_SCALE + 1) + 1);

    typedef struct packed {
        logic [11:0]      px;
        logic [11:0]      py;
        logic [SW-1:0]    s;
        logic [8:0]       beat;
        logic             five;
        logic             inframe;
        glyph_t [4:0]     glyphs;
    } s1_t;

    typedef struct packed {
        logic [XW-1:0]    dx;
        logic [XW-1:0]    dy;
        logic [SW-1:0]    s;
        logic             five;
        logic             inframe;
        glyph_t [4:0]     glyphs;
        logic [2:0][16:0] prod;
    } s2_t;

    typedef struct packed {
        glyph_t           glyph;
        logic [LW-1:0]    lx;
        logic [LW-1:0]    ly;
        logic             ly_ok;
        logic [SW-1:0]    s;
        logic             inframe;
        logic [23:0]      rgb;
    } s3_t;

    logic [23:0] text_rgb_reg;
    logic [3:0]  base_scale_reg;
    logic        blink_colon_reg;
    logic [11:0] frame_width_reg;
    logic [11:0] frame_height_reg;

    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    logic        done_reg;
    s1_t         s1_reg;
    s1_t         s1_next;
    s2_t         s2_reg;
    s2_t         s2_next;
    s3_t         s3_reg;
    s3_t         s3_next;
    kind_t       kind_reg;
    kind_t       kind_next;
    logic [23:0] rgb_reg;
    logic [23:0] rgb_next;

    logic [XW-1:0] fw_c;
    logic [XW-1:0] fh_c;
    logic [SW-1:0] sc_c;
    logic [4:0]    bs5;
    logic [4:0]    h12;
    logic [4:0]    hu;
    logic [5:0]    mt;
    logic [5:0]    mu;
    logic          htens;

    logic signed [XW-1:0] s_x;
    logic signed [XW-1:0] tw;
    logic signed [XW-1:0] vx;
    logic signed [XW-1:0] vy;
    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] y0;
    logic signed [XW-1:0] dx3;
    logic signed [XW-1:0] dy3;
    logic signed [XW-1:0] s3x;
    logic signed [XW-1:0] six;
    logic signed [XW-1:0] off;
    logic [2:0]           p;
    logic                 band;
    hit_t                 hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_rgb_reg     <= 24'hFFFFFF;
            base_scale_reg   <= 4'd1;
            blink_colon_reg  <= 1'b0;
            frame_width_reg  <= 12'd640;
            frame_height_reg <= 12'd480;
        end
        else if (wr_en)
        begin
            unique case (cfg_idx_t'(wr_index))
                CFG_TEXT_RGB:     text_rgb_reg     <= wr_data[23:0];
                CFG_BASE_SCALE:   base_scale_reg   <= wr_data[3:0];
                CFG_BLINK_COLON:  blink_colon_reg  <= wr_data[0];
                CFG_FRAME_WIDTH:  frame_width_reg  <= wr_data[11:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= wr_data[11:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        fw_c = (XW'(frame_width_reg) > XW'(MAX_FRAME)) ? XW'(MAX_FRAME)
                                                        : XW'(frame_width_reg);
        fh_c = (XW'(frame_height_reg) > XW'(MAX_FRAME)) ? XW'(MAX_FRAME)
                                                         : XW'(frame_height_reg);
        bs5 = {1'b0, base_scale_reg};
        if (bs5 == 5'd0)
        begin
            bs5 = 5'd1;
        end
        else if (bs5 > 5'(MAX_SCALE))
        begin
            bs5 = 5'(MAX_SCALE);
        end
        sc_c = SW'(bs5);
    end

    // Stage 1: digit decode, scale, beat clamp and frame test.
    always_comb
    begin
        if (hours >= 5'd24)
        begin
            h12 = hours - 5'd24;
        end
        else if (hours >= 5'd12)
        begin
            h12 = hours - 5'd12;
        end
        else
        begin
            h12 = hours;
        end
        if (h12 == 5'd0)
        begin
            h12 = 5'd12;
        end
        htens = h12 >= 5'd10;
        hu    = htens ? h12 - 5'd10 : h12;
        mt    = 6'd0;
        for (int k = 1; k <= 6; k++)
        begin
            mt = mt + 6'(minutes >= 6'(10 * k));
        end
        mu = minutes - 6'(mt * 6'd10);

        s1_next.px      = pixel_x;
        s1_next.py      = pixel_y;
        s1_next.beat    = (beat_level > 9'(BEAT_ONE)) ? 9'(BEAT_ONE) : beat_level;
        s1_next.s       = sc_c + SW'(beat_level > 9'(BEAT_THRESH));
        s1_next.five    = htens;
        s1_next.inframe = (XW'(pixel_x) < fw_c) && (XW'(pixel_y) < fh_c);
        s1_next.glyphs[0] = htens ? GLYPH_ONE : GLYPH_BLANK;
        s1_next.glyphs[1] = hu[3:0];
        s1_next.glyphs[2] = (!blink_colon_reg || millis < 10'(HALF_SECOND))
                            ? GLYPH_COLON : GLYPH_BLANK;
        s1_next.glyphs[3] = mt[3:0];
        s1_next.glyphs[4] = mu[3:0];
    end

    // Stage 2: centering and offsets from the text origin, blend products.
    always_comb
    begin
        s_x = $signed(XW'(s1_reg.s));
        tw  = s1_reg.five ? XW'(s_x * 29) : XW'(s_x * 23);
        vx  = $signed(fw_c) - tw;
        vy  = $signed(fh_c) - XW'(s_x * 7);
        x0  = (vx + $signed(XW'(vx[XW-1]))) >>> 1;
        y0  = (vy + $signed(XW'(vy[XW-1]))) >>> 1;

        s2_next.dx      = $signed(XW'(s1_reg.px)) - x0;
        s2_next.dy      = $signed(XW'(s1_reg.py)) - y0;
        s2_next.s       = s1_reg.s;
        s2_next.five    = s1_reg.five;
        s2_next.inframe = s1_reg.inframe;
        s2_next.glyphs  = s1_reg.glyphs;
        for (int c = 0; c < 3; c++)
        begin
            s2_next.prod[c] = 17'(s1_reg.beat) * 17'(8'd255 - text_rgb_reg[c*8 +: 8]);
        end
    end

    // Stage 3: glyph slot selection, local dot coordinates and the blended text color.
    always_comb
    begin
        dx3  = $signed(s2_reg.dx);
        dy3  = $signed(s2_reg.dy);
        s3x  = $signed(XW'(s2_reg.s));
        six  = XW'(s3x * 6);
        band = (dx3 >= 0) && (dx3 < XW'(six * 5));
        p    = 3'd0;
        for (int k = 1; k <= 4; k++)
        begin
            p = p + 3'(dx3 >= XW'(six * k));
        end
        off = XW'(six * $signed({1'b0, p}));

        if (!band)
        begin
            s3_next.glyph = GLYPH_BLANK;
        end
        else if (s2_reg.five)
        begin
            s3_next.glyph = s2_reg.glyphs[p];
        end
        else if (p == 3'd4)
        begin
            s3_next.glyph = GLYPH_BLANK;
        end
        else
        begin
            s3_next.glyph = s2_reg.glyphs[p + 3'd1];
        end
        s3_next.lx      = LW'(dx3 - off);
        s3_next.ly      = LW'(dy3);
        s3_next.ly_ok   = (dy3 >= 0) && (dy3 <= XW'(s3x * 7));
        s3_next.s       = s2_reg.s;
        s3_next.inframe = s2_reg.inframe;
        for (int c = 0; c < 3; c++)
        begin
            s3_next.rgb[c*8 +: 8] = text_rgb_reg[c*8 +: 8] + s2_reg.prod[c][15:8];
        end
    end

    cop_glyph_hit #(
        .SW (SW),
        .LW (LW)
    ) u_hit (
        .glyph (s3_reg.glyph),
        .lx    (s3_reg.lx),
        .ly    (s3_reg.ly),
        .ly_ok (s3_reg.ly_ok),
        .s     (s3_reg.s),
        .hit   (hit)
    );

    // Stage 4: main text wins over the shadow.
    always_comb
    begin
        if (s3_reg.inframe && hit.main)
        begin
            kind_next = KIND_TEXT;
            rgb_next  = s3_reg.rgb;
        end
        else if (s3_reg.inframe && hit.shadow)
        begin
            kind_next = KIND_SHADOW;
            rgb_next  = 24'd0;
        end
        else
        begin
            kind_next = KIND_NONE;
            rgb_next  = 24'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg   <= s1_next;
        s2_reg   <= s2_next;
        s3_reg   <= s3_next;
        kind_reg <= kind_next;
        rgb_reg  <= rgb_next;
    end

    assign busy       = 1'b0;
    assign done       = done_reg;
    assign pixel_kind = kind_reg;
    assign pixel_rgb  = rgb_reg;

endmodule

`default_nettype wire

FILE: rtl/core/cop_checker.sv
`default_nettype none

module cop_checker
    import cop_pkg::*;
(
    input wire        clk,
    input wire        rst_n,
    input wire        start,
    input wire        busy,
    input wire        done,
    input wire [1:0]  pixel_kind,
    input wire [23:0] pixel_rgb
);

    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("Result item without an accepted item four cycles earlier.");

    a_item_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(start && !busy, 4) && $past(rst_n, 1) && $past(rst_n, 2)
         && $past(rst_n, 3) && $past(rst_n, 4)) |-> done)
        else $error("Accepted item produced no result item.");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pixel_kind == KIND_NONE || pixel_kind == KIND_SHADOW
                  || pixel_kind == KIND_TEXT))
        else $error("Illegal pixel kind.");

    a_rgb_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pixel_kind != KIND_TEXT) |-> (pixel_rgb == 24'd0))
        else $error("Non-text pixel carries a color.");

endmodule

bind clock_overlay_pixel_generator cop_checker u_cop_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .pixel_kind (pixel_kind),
    .pixel_rgb  (pixel_rgb)
);

`default_nettype wire
